// ===== sv/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types and constants for the MT19937 generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS);
    localparam int IDX_W        = $clog2(STATE_WORDS + 2);

    localparam logic [IDX_W-1:0]  IDX_FULL       = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0]  IDX_NOT_SEEDED = IDX_W'(STATE_WORDS + 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST      = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] ADDR_FAR       = ADDR_W'(TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] ADDR_WRAP      = ADDR_W'(STATE_WORDS - TWIST_OFFSET);

    localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] SEED_DEFAULT = 32'd5489;

    localparam logic REQ_GENERATE = 1'b0;
    localparam logic REQ_RESEED   = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [30:0] range_limit;
    } t_in_item;

    typedef struct packed {
        logic [31:0] random_word;
        logic [30:0] scaled_value;
    } t_out_item;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mtg_ram.sv =====
// ----------------------------------------------------------------------------
// mtg_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== sv/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator with a 624-word state RAM and a scaled output.
// ----------------------------------------------------------------------------
// Generate: the result is registered after RAM read, temper and scale; no new item
//   is taken until the result is out. A stalled result holds the next one back.
// Using up the table adds a twist, one word per cycle; a generate
//   before any seed adds a fill first. Reseed: a fill of the table, no result.
// Reset (synchronous, active low): not seeded, seed register 5489, no result
//   pending. The state RAM is not cleared; it is always filled before read.
`default_nettype none

module mersenne_twister_generator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire mtg_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output mtg_pkg::t_out_item     o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [31:0]       i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_TW_PRIME,
        S_TWIST,
        S_RD,
        S_TEMP,
        S_MUL
    } t_state;

    t_state                           r_state;
    logic [mtg_pkg::IDX_W-1:0]        r_idx;
    logic [mtg_pkg::ADDR_W-1:0]       r_k;
    logic [31:0]                      r_seed;
    logic [31:0]                      r_prev;
    logic [31:0]                      r_cur;
    logic [31:0]                      r_word0;
    logic [31:0]                      r_word;
    logic [30:0]                      r_range;
    logic                             r_gen;
    logic                             r_out_valid;
    mtg_pkg::t_out_item               r_out;

    logic                             ram_we;
    logic [mtg_pkg::ADDR_W-1:0]       ram_waddr;
    logic [31:0]                      ram_wdata;
    logic [mtg_pkg::ADDR_W-1:0]       ram_raddr_a;
    logic [mtg_pkg::ADDR_W-1:0]       ram_raddr_b;
    logic [31:0]                      ram_rdata_a;
    logic [31:0]                      ram_rdata_b;

    logic [31:0]                      seed_mix;
    logic [31:0]                      seed_word;
    logic [31:0]                      tw_y;
    logic [31:0]                      tw_word;
    logic [mtg_pkg::ADDR_W-1:0]       k_next;
    logic [mtg_pkg::ADDR_W-1:0]       nxt_addr;
    logic [mtg_pkg::ADDR_W-1:0]       far_addr;
    logic [62:0]                      scale_prod;

    mtg_ram #(
        .WIDTH(32),
        .DEPTH(mtg_pkg::STATE_WORDS)
    ) u_state_ram (
        .i_clk      (i_clk),
        .i_wr_en    (ram_we),
        .i_wr_addr  (ram_waddr),
        .i_wr_data  (ram_wdata),
        .i_rd_addr_a(ram_raddr_a),
        .o_rd_data_a(ram_rdata_a),
        .i_rd_addr_b(ram_raddr_b),
        .o_rd_data_b(ram_rdata_b)
    );

    // fill recurrence: word k from word k-1
    always_comb begin
        seed_mix  = r_prev ^ (r_prev >> 30);
        seed_word = (r_k == '0) ? r_seed
                  : seed_mix * mtg_pkg::SEED_MULT + {{(32 - mtg_pkg::ADDR_W){1'b0}}, r_k};
    end

    // twist of word k: r_cur is old word k, port A old word k+1, port B word k+397
    always_comb begin
        tw_y    = (r_cur & mtg_pkg::HIGH_BIT) | (ram_rdata_a & mtg_pkg::LOW_BITS);
        tw_word = ram_rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::TWIST_XOR : 32'h0);
    end

    // read addresses for the word after r_k
    always_comb begin
        k_next   = r_k + 1'b1;
        nxt_addr = (k_next == mtg_pkg::ADDR_LAST) ? '0 : k_next + 1'b1;
        far_addr = (k_next < mtg_pkg::ADDR_WRAP) ? k_next + mtg_pkg::ADDR_FAR
                                                 : k_next - mtg_pkg::ADDR_WRAP;
    end

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_k;
        ram_wdata   = tw_word;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        unique case (r_state)
            S_SEED: begin
                ram_we    = 1'b1;
                ram_wdata = seed_word;
            end
            S_TW_PRIME: begin
                ram_raddr_a = mtg_pkg::ADDR_W'(1);
                ram_raddr_b = mtg_pkg::ADDR_FAR;
            end
            S_TWIST: begin
                ram_we      = 1'b1;
                ram_raddr_a = nxt_addr;
                ram_raddr_b = far_addr;
            end
            S_RD: begin
                ram_raddr_a = r_idx[mtg_pkg::ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign scale_prod = {31'b0, r_word} * {32'b0, r_range};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= mtg_pkg::IDX_NOT_SEEDED;
            r_seed      <= mtg_pkg::SEED_DEFAULT;
            r_gen       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && r_state != S_MUL) begin
                r_out_valid <= 1'b0;
            end
            // keep old word 0 at hand, the twist needs it with two other reads
            if (ram_we && ram_waddr == '0) begin
                r_word0 <= ram_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_range <= i_in_item.range_limit;
                        r_k     <= '0;
                        r_gen   <= (i_in_item.req_type != mtg_pkg::REQ_RESEED) &&
                                   (r_idx == mtg_pkg::IDX_NOT_SEEDED);
                        priority if (i_in_item.req_type == mtg_pkg::REQ_RESEED) begin
                            r_state <= S_SEED;
                        end else if (r_idx == mtg_pkg::IDX_NOT_SEEDED) begin
                            r_state <= S_SEED;
                        end else if (r_idx == mtg_pkg::IDX_FULL) begin
                            r_state <= S_TW_PRIME;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_SEED: begin
                    r_prev <= seed_word;
                    r_k    <= (r_k == mtg_pkg::ADDR_LAST) ? '0 : r_k + 1'b1;
                    if (r_k == mtg_pkg::ADDR_LAST) begin
                        r_idx   <= mtg_pkg::IDX_FULL;
                        r_state <= r_gen ? S_TW_PRIME : S_IDLE;
                    end
                end
                S_TW_PRIME: begin
                    r_k     <= '0;
                    r_cur   <= r_word0;
                    r_state <= S_TWIST;
                end
                S_TWIST: begin
                    r_cur <= ram_rdata_a;
                    r_k   <= k_next;
                    if (r_k == mtg_pkg::ADDR_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_TEMP;
                end
                S_TEMP: begin
                    r_word  <= mtg_pkg::temper(ram_rdata_a);
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid        <= 1'b1;
                        r_out.random_word  <= r_word;
                        r_out.scaled_value <= scale_prod[62:32];
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= mtg_pkg::IDX_NOT_SEEDED)
        else $error("read index out of range");

    a_rd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> r_idx < mtg_pkg::IDX_FULL)
        else $error("table read with no word left");

    a_seed_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED && r_k == mtg_pkg::ADDR_LAST) |=> r_idx == mtg_pkg::IDX_FULL)
        else $error("fill did not leave the table full");

    a_twist_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TWIST && r_k == mtg_pkg::ADDR_LAST) |=> (r_state == S_RD && r_idx == '0))
        else $error("twist did not hand over to the read");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator
// Self-checking bench for the MT19937 generator: a short table of probe
// requests (default seed, reseeds, range extremes), then random traffic over
// several seed settings with varying idle and stall pressure. An in-bench
// model of the state table predicts every word and its scaled value.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::*;

    localparam int NOT_SEEDED     = STATE_WORDS + 1;
    localparam int SETTLE_CYCLES  = 700;    // covers a reseed still running
    localparam int WATCHDOG_LIMIT = 6000;   // fill + twist + stalls, several times over
    localparam int LONG_HOLD      = 300;
    localparam int NUM_PHASES     = 6;
    localparam int NUM_PROBES     = 17;

    typedef struct {
        logic        req;
        logic [30:0] lim;
        bit          typed;
        logic [31:0] word;
        logic [30:0] scaled;
    } t_probe_row;

    // First outputs for seed 5489 are well known; the rest come from the model.
    t_probe_row probe_rows [NUM_PROBES] = '{
        '{REQ_GENERATE, 31'd0,          1'b1, 32'd3499211612, 31'd0},
        '{REQ_GENERATE, 31'h7fff_ffff,  1'b1, 32'd581869302,  31'd290934650},
        '{REQ_GENERATE, 31'd1,          1'b1, 32'd3890346734, 31'd0},
        '{REQ_GENERATE, 31'h4000_0000,  1'b0, 32'd0,          31'd0},
        '{REQ_GENERATE, 31'h5555_5555,  1'b0, 32'd0,          31'd0},
        '{REQ_GENERATE, 31'h2aaa_aaaa,  1'b0, 32'd0,          31'd0},
        '{REQ_RESEED,   31'h7fff_ffff,  1'b0, 32'd0,          31'd0},
        '{REQ_GENERATE, 31'd0,          1'b1, 32'd3499211612, 31'd0},
        '{REQ_GENERATE, 31'd1,          1'b1, 32'd581869302,  31'd0},
        '{REQ_RESEED,   31'd0,          1'b0, 32'd0,          31'd0},
        '{REQ_RESEED,   31'h2aaa_aaaa,  1'b0, 32'd0,          31'd0},
        '{REQ_GENERATE, 31'h7fff_ffff,  1'b1, 32'd3499211612, 31'd1749605805},
        '{REQ_GENERATE, 31'd2,          1'b1, 32'd581869302,  31'd0},
        '{REQ_GENERATE, 31'd2,          1'b1, 32'd3890346734, 31'd1},
        '{REQ_GENERATE, 31'd1000,       1'b0, 32'd0,          31'd0},
        '{REQ_GENERATE, 31'h7fff_fffe,  1'b0, 32'd0,          31'd0},
        '{REQ_GENERATE, 31'd12345,      1'b0, 32'd0,          31'd0}
    };

    // per phase: item count, reseed rate in permille, reseed first, idle pcts
    int unsigned phase_items   [NUM_PHASES] = '{250, 250, 400, 400, 250, 250};
    int unsigned phase_reseed  [NUM_PHASES] = '{10, 20, 0, 0, 15, 0};
    bit          phase_restart [NUM_PHASES] = '{1, 1, 1, 0, 1, 0};
    int unsigned phase_src_pct [NUM_PHASES] = '{35, 35, 75, 75, 0, 0};
    int unsigned phase_rcv_pct [NUM_PHASES] = '{75, 75, 35, 35, 0, 0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        o_cfg_ready;

    // generator model
    logic [31:0] mt_table [STATE_WORDS];
    int unsigned mt_pos;
    logic [31:0] seed_reg;

    t_out_item   pending_draws [$];
    int unsigned src_idle_pct;
    int unsigned rcv_idle_pct;
    bit          long_hold_pending = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fails = 0;
    int unsigned n_draws = 0;
    int unsigned n_reseeds = 0;
    int unsigned n_twists = 0;

    mersenne_twister_generator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void seed_table();
        logic [31:0] w;
        mt_table[0] = seed_reg;
        for (int i = 1; i < STATE_WORDS; i++) begin
            w = mt_table[i-1];
            mt_table[i] = (w ^ (w >> 30)) * SEED_MULT + 32'(i);
        end
        mt_pos = STATE_WORDS;
    endfunction

    function automatic void twist_table();
        logic [31:0] y;
        logic [31:0] v;
        for (int k = 0; k < STATE_WORDS; k++) begin
            y = (mt_table[k] & HIGH_BIT) | (mt_table[(k + 1) % STATE_WORDS] & LOW_BITS);
            v = mt_table[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0]) begin
                v = v ^ TWIST_XOR;
            end
            mt_table[k] = v;
        end
        mt_pos = 0;
        n_twists++;
    endfunction

    function automatic logic [31:0] temper_word(input logic [31:0] raw);
        logic [31:0] t;
        t = raw;
        t ^= t >> 11;
        t ^= (t << 7) & TEMPER_B;
        t ^= (t << 15) & TEMPER_C;
        t ^= t >> 18;
        return t;
    endfunction

    // Advances the model by one request; returns 1 when it yields a number.
    function automatic bit draw_number(input t_in_item it, output t_out_item res);
        logic [63:0] prod;
        res = '0;
        if (it.req_type == REQ_RESEED) begin
            seed_table();
            n_reseeds++;
            return 1'b0;
        end
        if (mt_pos >= STATE_WORDS) begin
            if (mt_pos != STATE_WORDS) begin
                seed_table();
            end
            twist_table();
        end
        res.random_word  = temper_word(mt_table[mt_pos]);
        mt_pos++;
        prod             = {32'd0, res.random_word} * {33'd0, it.range_limit};
        res.scaled_value = prod[62:32];
        return 1'b1;
    endfunction

    function automatic t_in_item rand_request(input int unsigned reseed_pm);
        t_in_item it;
        it.req_type = ($urandom_range(999) < reseed_pm) ? REQ_RESEED : REQ_GENERATE;
        case ($urandom_range(7))
            0: begin
                it.range_limit = '0;
            end
            1: begin
                it.range_limit = '1;
            end
            2: begin
                it.range_limit = 31'($urandom_range(16, 1));
            end
            default: begin
                it.range_limit = 31'($urandom);
            end
        endcase
        return it;
    endfunction

    // Called right after a rising edge; returns at the edge that takes the item.
    task automatic send_request(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        if ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (o_in_stall);
        if (draw_number(it, res)) begin
            pending_draws.push_back(typed ? typed_res : res);
            n_draws++;
        end
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        seed_reg = s;
    endtask

    // result side: check, then pick the stall for the next cycle
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_draws.size() == 0) begin
                fails++;
                $error("unexpected result: word %h scaled %h",
                       o_out_item.random_word, o_out_item.scaled_value);
            end else begin
                want = pending_draws.pop_front();
                if (o_out_item.random_word !== want.random_word) begin
                    fails++;
                    $error("random_word: expected %h, got %h",
                           want.random_word, o_out_item.random_word);
                end
                if (o_out_item.scaled_value !== want.scaled_value) begin
                    fails++;
                    $error("scaled_value: expected %h, got %h",
                           want.scaled_value, o_out_item.scaled_value);
                end
            end
        end
        if (long_hold_pending) begin
            hold_left = LONG_HOLD;
            long_hold_pending = 1'b0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item typed_res;
        logic [31:0] seeds [NUM_PHASES];

        seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, $urandom, $urandom, $urandom};
        seed_reg     = SEED_DEFAULT;
        mt_pos       = NOT_SEEDED;
        src_idle_pct = 35;
        rcv_idle_pct = 75;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // probes: unseeded first draw, reseeds, range extremes
        foreach (probe_rows[r]) begin
            it.req_type           = probe_rows[r].req;
            it.range_limit        = probe_rows[r].lim;
            typed_res.random_word  = probe_rows[r].word;
            typed_res.scaled_value = probe_rows[r].scaled;
            send_request(it, probe_rows[r].typed, typed_res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_quiet();
            write_seed(seeds[p]);
            src_idle_pct = phase_src_pct[p];
            rcv_idle_pct = phase_rcv_pct[p];
            if (p == 4) begin
                long_hold_pending = 1'b1;   // back up the block with input still offered
            end
            for (int n = 0; n < phase_items[p]; n++) begin
                it = rand_request(phase_reseed[p]);
                if (n == 0 && phase_restart[p]) begin
                    it.req_type = REQ_RESEED;
                end
                send_request(it, 1'b0, typed_res);
            end
        end

        wait_quiet();
        if (pending_draws.size() != 0) begin
            fails++;
            $error("%0d expected results never arrived", pending_draws.size());
        end

        $display("covered %0d draws, %0d reseeds, %0d table twists over %0d seed settings",
                 n_draws, n_reseeds, n_twists, NUM_PHASES + 1);
        $display("seeds included 0 and all ones; ranges 0, 1, 2 and the 31-bit maximum");
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
